// File: hw/rtl/atl_pkg.sv
// atl_pkg: widths, constants and the arctangent table of the tilt block
// no dependencies

package atl_pkg;

   // sample and result widths
   localparam int RAW_W    = 16;
   localparam int AXIS_W   = 17;
   localparam int ANGLE_W  = 16;
   localparam int TEMP_W   = 17;
   localparam int CSR_IDX_W = 3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X    = 3'd0,
      CSR_OFFSET_Y    = 3'd1,
      CSR_OFFSET_Z    = 3'd2,
      CSR_OFFSET_TEMP = 3'd3
   } csr_index_type;

   // angle datapath
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int SQ_W     = 34;            // b^2 + c^2, up to 2^33
   localparam int NUM_W    = SQ_W + 16;     // radicand, scaled by 2^16
   localparam int ROOT_W   = 25;
   localparam int CRD_W    = 28;            // cordic x and y
   localparam int ZACC_W   = 32;            // angle accumulator, degrees * 2^24
   localparam int CRD_STEPS = 24;

   // pipeline depths
   localparam int TILT_LAT = 2 + ROOT_W + CRD_STEPS + 1;
   localparam int TEMP_LAT = 3;             // numerator, product, saturation
   localparam int TOP_LAT  = 1 + TILT_LAT;

   // temperature: floor((t*6400 + 79493530) / 8500), lifted positive first
   localparam int TEMP_SCALE = 6400;
   localparam int TEMP_BIAS  = 79493530;
   localparam int TEMP_DIV   = 8500;
   localparam int TEMP_LIFT  = 40000;
   localparam int TEMP_NUM_W = 30;
   localparam int TEMP_MIN   = -25000;
   localparam int TEMP_MAX   = 35000;

   // ceil(2^44 / 8500): exact quotient for any numerator below 2^30
   localparam int TEMP_RECIP_W  = 31;
   localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = 31'd2069668947;
   localparam int TEMP_RECIP_SH = 44;

   // atan(2^-i) in degrees * 2^24
   function automatic logic signed [ZACC_W-1:0] atan_q24(input int i);
      logic signed [ZACC_W-1:0] v;
      case (i)
         0:  v = 32'sd754974720;
         1:  v = 32'sd445687602;
         2:  v = 32'sd235489088;
         3:  v = 32'sd119537938;
         4:  v = 32'sd60000934;
         5:  v = 32'sd30029717;
         6:  v = 32'sd15018523;
         7:  v = 32'sd7509720;
         8:  v = 32'sd3754917;
         9:  v = 32'sd1877466;
         10: v = 32'sd938734;
         11: v = 32'sd469367;
         12: v = 32'sd234684;
         13: v = 32'sd117342;
         14: v = 32'sd58671;
         15: v = 32'sd29335;
         16: v = 32'sd14668;
         17: v = 32'sd7334;
         18: v = 32'sd3667;
         19: v = 32'sd1833;
         20: v = 32'sd917;
         21: v = 32'sd458;
         22: v = 32'sd229;
         23: v = 32'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/atl_delay.sv
// atl_delay: fixed-length shift line for data travelling beside a pipeline
// no dependencies

module atl_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] line_ff [0:DEPTH-1];

   // shift every cycle
   always_ff @(posedge clock) begin
      line_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign d_out = line_ff[DEPTH-1];

endmodule

// File: hw/rtl/atl_isqrt.sv
// atl_isqrt: pipelined integer square root, one root bit per stage
// depends on atl_pkg

module atl_isqrt (
   input  logic                        clock,
   input  logic [atl_pkg::NUM_W-1:0]   num_in,
   output logic [atl_pkg::ROOT_W-1:0]  root_out
);

   localparam int NW = atl_pkg::NUM_W;
   localparam int RW = atl_pkg::ROOT_W;
   localparam int TW = NW + 2;

   logic [NW-1:0] rem_ff  [0:RW];
   logic [RW-1:0] root_ff [0:RW];

   assign rem_ff[0]  = num_in;
   assign root_ff[0] = '0;

   // stage s settles root bit RW-1-s
   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic [TW-1:0] trial;
      logic          take;
      always_comb begin
         trial = ({{(TW-RW){1'b0}}, root_ff[s]} << (K + 1)) + ({{(TW-1){1'b0}}, 1'b1} << (2 * K));
         take  = {2'b00, rem_ff[s]} >= trial;
      end
      always_ff @(posedge clock) begin
         if (take) begin
            rem_ff[s+1]  <= rem_ff[s] - trial[NW-1:0];
            root_ff[s+1] <= root_ff[s] | (RW'(1) << K);
         end else begin
            rem_ff[s+1]  <= rem_ff[s];
            root_ff[s+1] <= root_ff[s];
         end
      end
   end

   assign root_out = root_ff[RW];

endmodule

// File: hw/rtl/atl_cordic.sv
// atl_cordic: pipelined cordic vectoring, one micro-rotation per stage
// depends on atl_pkg

module atl_cordic (
   input  logic                                clock,
   input  logic signed [atl_pkg::CRD_W-1:0]    x_in,
   input  logic signed [atl_pkg::CRD_W-1:0]    y_in,
   output logic signed [atl_pkg::ZACC_W-1:0]   z_out
);

   localparam int N = atl_pkg::CRD_STEPS;

   logic signed [atl_pkg::CRD_W-1:0]  x_ff [0:N];
   logic signed [atl_pkg::CRD_W-1:0]  y_ff [0:N];
   logic signed [atl_pkg::ZACC_W-1:0] z_ff [0:N];

   assign x_ff[0] = x_in;
   assign y_ff[0] = y_in;
   assign z_ff[0] = '0;

   // rotate towards y = 0, adding up the angle
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [atl_pkg::CRD_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (!y_ff[i][atl_pkg::CRD_W-1]) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + atl_pkg::atan_q24(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - atl_pkg::atan_q24(i);
         end
      end
   end

   assign z_out = z_ff[N];

endmodule

// File: hw/rtl/atl_tilt.sv
// atl_tilt: tilt angle of one axis against the other two
// depends on atl_pkg, atl_isqrt, atl_cordic, atl_delay

module atl_tilt #(
   parameter int ANGLE_FRAC_BITS = atl_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic signed [atl_pkg::AXIS_W-1:0]    a_in,
   input  logic signed [atl_pkg::AXIS_W-1:0]    b_in,
   input  logic signed [atl_pkg::AXIS_W-1:0]    c_in,
   output logic signed [atl_pkg::ANGLE_W-1:0]   angle_out
);

   localparam int AW = atl_pkg::AXIS_W;
   localparam int SW = atl_pkg::SQ_W;
   localparam int FW = 33;
   localparam int FLAG_LAT = atl_pkg::ROOT_W + atl_pkg::CRD_STEPS;

   logic signed [SW-1:0]             pb, pc;
   logic [atl_pkg::SQ_W-2:0]         sqb_ff, sqc_ff;
   logic signed [AW-1:0]             a1_ff;
   logic [atl_pkg::NUM_W-1:0]        num_ff;
   logic signed [atl_pkg::CRD_W-1:0] y0_ff;
   logic [2:0]                       flag_ff;   // a zero, sum zero, a negative
   logic [atl_pkg::ROOT_W-1:0]       root;
   logic signed [atl_pkg::CRD_W-1:0] y0_dly;
   logic [2:0]                       flag_dly;
   logic signed [atl_pkg::ZACC_W-1:0] z;
   logic signed [FW-1:0]             rnd, ang, lim, clip;
   logic signed [atl_pkg::ANGLE_W-1:0] ang16, lim16, angle_in, angle_ff;
   logic [atl_pkg::SQ_W-1:0]         sq_sum;

   // squares of the other two axes
   assign pb = SW'(b_in) * SW'(b_in);
   assign pc = SW'(c_in) * SW'(c_in);
   always_ff @(posedge clock) begin
      sqb_ff <= pb[SW-2:0];
      sqc_ff <= pc[SW-2:0];
      a1_ff  <= a_in;
   end

   // radicand, start vector and special-case flags
   assign sq_sum = {1'b0, sqb_ff} + {1'b0, sqc_ff};
   always_ff @(posedge clock) begin
      num_ff  <= {sq_sum, 16'h0000};
      y0_ff   <= {{(atl_pkg::CRD_W-AW-8){a1_ff[AW-1]}}, a1_ff, 8'h00};
      flag_ff <= {a1_ff == '0, sq_sum == '0, a1_ff[AW-1]};
   end

   atl_isqrt u_isqrt (
      .clock    (clock),
      .num_in   (num_ff),
      .root_out (root)
   );

   atl_delay #(.WIDTH(atl_pkg::CRD_W), .DEPTH(atl_pkg::ROOT_W)) u_y0_dly (
      .clock (clock),
      .d_in  (y0_ff),
      .d_out (y0_dly)
   );

   atl_cordic u_cordic (
      .clock (clock),
      .x_in  ({{(atl_pkg::CRD_W-atl_pkg::ROOT_W){1'b0}}, root}),
      .y_in  (y0_dly),
      .z_out (z)
   );

   atl_delay #(.WIDTH(3), .DEPTH(FLAG_LAT)) u_flag_dly (
      .clock (clock),
      .d_in  (flag_ff),
      .d_out (flag_dly)
   );

   // round to the output fraction, clamp to +-90 degrees, saturate; a zero gives 0, else zero b and c give +-90
   always_comb begin
      rnd  = {z[atl_pkg::ZACC_W-1], z} + (FW'(1) <<< (23 - ANGLE_FRAC_BITS));
      ang  = rnd >>> (24 - ANGLE_FRAC_BITS);
      lim  = FW'(90) <<< ANGLE_FRAC_BITS;
      clip = ang;
      if (ang > lim) clip = lim;
      if (ang < -lim) clip = -lim;
      if (clip > FW'(32767)) ang16 = 16'sd32767;
      else if (clip < -FW'(32768)) ang16 = -16'sd32768;
      else ang16 = clip[atl_pkg::ANGLE_W-1:0];
      if (lim > FW'(32767)) lim16 = 16'sd32767;
      else lim16 = lim[atl_pkg::ANGLE_W-1:0];
      if (flag_dly[2]) angle_in = '0;
      else if (flag_dly[1]) angle_in = flag_dly[0] ? ((lim > FW'(32767)) ? -16'sd32768 : -lim16)
                                                     : lim16;
      else angle_in = ang16;
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle_out = angle_ff;

endmodule

// File: hw/rtl/atl_temp.sv
// atl_temp: temperature scaling by reciprocal multiplication with a constant divisor
// depends on atl_pkg

module atl_temp (
   input  logic                                clock,
   input  logic signed [atl_pkg::AXIS_W-1:0]   t_in,
   output logic signed [atl_pkg::TEMP_W-1:0]   temp_out
);

   localparam int NW = atl_pkg::TEMP_NUM_W;
   localparam int QW = atl_pkg::TEMP_W;
   localparam int RW = atl_pkg::TEMP_RECIP_W;
   localparam int PW = NW + RW;
   localparam int LIFT_NUM = atl_pkg::TEMP_BIAS + atl_pkg::TEMP_DIV * atl_pkg::TEMP_LIFT;

   logic signed [31:0]   prod;
   logic [NW-1:0]        num_ff;
   logic [PW-1:0]        mul_ff;
   logic signed [QW:0]   q;
   logic signed [QW-1:0] temp_ff;

   // scaled numerator, lifted to stay positive
   assign prod = 32'(t_in) * 32'(atl_pkg::TEMP_SCALE) + 32'(LIFT_NUM);
   always_ff @(posedge clock) begin
      num_ff <= prod[NW-1:0];
   end

   // quotient by multiplying with the rounded-up reciprocal
   always_ff @(posedge clock) begin
      mul_ff <= PW'(num_ff) * PW'(atl_pkg::TEMP_RECIP);
   end

   // remove the lift and saturate
   assign q = $signed({1'b0, mul_ff[atl_pkg::TEMP_RECIP_SH +: QW]})
              - (QW+1)'(atl_pkg::TEMP_LIFT);
   always_ff @(posedge clock) begin
      if (q > (QW+1)'(atl_pkg::TEMP_MAX)) temp_ff <= QW'(atl_pkg::TEMP_MAX);
      else if (q < (QW+1)'(atl_pkg::TEMP_MIN)) temp_ff <= QW'(atl_pkg::TEMP_MIN);
      else temp_ff <= q[QW-1:0];
   end

   assign temp_out = temp_ff;

endmodule

// File: hw/rtl/accel_tilt_angles_top.sv
// accel_tilt_angles_top: tilt angles and die temperature from raw samples
// depends on atl_pkg, atl_tilt, atl_temp, atl_delay
//
// Usage: drive a raw sample on req_accel_x/y/z and req_temp_raw with start
// high; busy is always low, so a request is taken every cycle start is high.
// Offsets are written through csr_we, csr_index and csr_wdata (index 0 to 3
// for x, y, z and temperature; other indexes are ignored); the user is to
// write them only while idle, which the block does not enforce. Each request
// gives one result, shown for one cycle with rsp_valid high; rsp_valid is
// aligned with the result of its request. Throughput is one request
// per cycle: square root and cordic are unrolled, one bit or one rotation
// per stage, and the temperature uses a reciprocal multiplication over
// three stages.
// The receiver cannot stall; results are never held back.
// Reset clears the offsets and all requests in flight.

module accel_tilt_angles_top #(
   parameter int ANGLE_FRAC_BITS = atl_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [atl_pkg::RAW_W-1:0]      req_accel_x,
   input  logic signed [atl_pkg::RAW_W-1:0]      req_accel_y,
   input  logic signed [atl_pkg::RAW_W-1:0]      req_accel_z,
   input  logic signed [atl_pkg::RAW_W-1:0]      req_temp_raw,
   input  logic                                  csr_we,
   input  logic [atl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic signed [atl_pkg::RAW_W-1:0]      csr_wdata,
   output logic                                  rsp_valid,
   output logic signed [atl_pkg::ANGLE_W-1:0]    rsp_angle_x,
   output logic signed [atl_pkg::ANGLE_W-1:0]    rsp_angle_y,
   output logic signed [atl_pkg::ANGLE_W-1:0]    rsp_angle_z,
   output logic signed [atl_pkg::TEMP_W-1:0]     rsp_temperature_c
);

   localparam int AW = atl_pkg::AXIS_W;
   localparam int LAT = atl_pkg::TOP_LAT;

   logic signed [atl_pkg::RAW_W-1:0] off_x_ff, off_y_ff, off_z_ff, off_t_ff;
   logic signed [AW-1:0] ax_ff, ay_ff, az_ff, at_ff;
   logic [LAT-1:0]       vld_ff;
   logic signed [atl_pkg::TEMP_W-1:0] temp_raw_c;

   assign busy = 1'b0;

   // offset registers
   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
         off_t_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            atl_pkg::CSR_OFFSET_X:    off_x_ff <= csr_wdata;
            atl_pkg::CSR_OFFSET_Y:    off_y_ff <= csr_wdata;
            atl_pkg::CSR_OFFSET_Z:    off_z_ff <= csr_wdata;
            atl_pkg::CSR_OFFSET_TEMP: off_t_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // corrected sample at 17 bits
   always_ff @(posedge clock) begin
      ax_ff <= AW'(req_accel_x) + AW'(off_x_ff);
      ay_ff <= AW'(req_accel_y) + AW'(off_y_ff);
      az_ff <= AW'(req_accel_z) + AW'(off_z_ff);
      at_ff <= AW'(req_temp_raw) + AW'(off_t_ff);
   end

   // request valid travels beside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   atl_tilt #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_tilt_x (
      .clock (clock), .a_in (ax_ff), .b_in (ay_ff), .c_in (az_ff),
      .angle_out (rsp_angle_x)
   );

   atl_tilt #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_tilt_y (
      .clock (clock), .a_in (ay_ff), .b_in (ax_ff), .c_in (az_ff),
      .angle_out (rsp_angle_y)
   );

   atl_tilt #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_tilt_z (
      .clock (clock), .a_in (az_ff), .b_in (ax_ff), .c_in (ay_ff),
      .angle_out (rsp_angle_z)
   );

   atl_temp u_temp (
      .clock    (clock),
      .t_in     (at_ff),
      .temp_out (temp_raw_c)
   );

   // line the temperature up with the angles
   atl_delay #(.WIDTH(atl_pkg::TEMP_W), .DEPTH(atl_pkg::TILT_LAT - atl_pkg::TEMP_LAT)) u_temp_dly (
      .clock (clock),
      .d_in  (temp_raw_c),
      .d_out (rsp_temperature_c)
   );

endmodule
